// ----- sv/earec_pkg.sv -----
// Package: shared types, constants and AES helper functions for the record decoder.
`timescale 1ns / 1ps
`default_nettype none
package earec_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_COMPANY   = 3'd2;
  localparam logic [2:0] ST_ADDRESS   = 3'd3;
  localparam logic [2:0] ST_UNDER_MIN = 3'd4;
  localparam logic [2:0] ST_KEYCHECK  = 3'd5;

  localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
  localparam logic [1:0] REG_KEY_LOW     = 2'd1;
  localparam logic [1:0] REG_TARGET_ADDR = 2'd2;
  localparam logic [1:0] REG_ADDR_FILTER = 2'd3;

  localparam logic [15:0] COMPANY_ID_OK = 16'h02E1;
  localparam logic [4:0]  SHORT_RECORD  = 5'd8;
  localparam logic [4:0]  MIN_RECORD    = 5'd20;
  localparam logic [4:0]  COUNT_MAX     = 5'd31;
  localparam logic [4:0]  IDX_CID_LO    = 5'd0;
  localparam logic [4:0]  IDX_CID_HI    = 5'd1;
  localparam logic [4:0]  IDX_CTR_LO    = 5'd7;
  localparam logic [4:0]  IDX_CTR_HI    = 5'd8;
  localparam logic [4:0]  IDX_KEYCHECK  = 5'd9;
  localparam logic [4:0]  CIPHER_START  = 5'd10;
  // only the first ten decrypted bytes carry readings
  localparam int          CIPHER_USED   = 10;
  localparam logic [3:0]  LAST_ROUND    = 4'd10;

  typedef logic [15:0][7:0] block_t;

  typedef struct packed {
    logic [2:0]                  status;
    logic [15:0]                 counter;
    logic [CIPHER_USED-1:0][7:0] cipher;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ----- sv/earec_front.sv -----
// Front end: collects record bytes, checks the record and queues a decode job.
`timescale 1ns / 1ps
`default_nettype none
module earec_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  input  wire logic [47:0]        sender_address,
  input  wire logic [7:0]         key_byte0,
  input  wire logic [47:0]        target_address,
  input  wire logic               address_filter_on,
  output earec_pkg::job_t         job,
  output logic                    job_push
);

  logic [4:0]  byte_count, byte_count_next, count_sat;
  logic [15:0] company_id, company_id_next;
  logic [15:0] counter_value, counter_value_next;
  logic [7:0]  key_check_byte, key_check_byte_next;
  logic [earec_pkg::CIPHER_USED-1:0][7:0] cipher, cipher_next;
  logic [2:0]  status;

  always_comb begin
    company_id_next     = company_id;
    counter_value_next  = counter_value;
    key_check_byte_next = key_check_byte;
    cipher_next         = cipher;
    case (byte_count)
      earec_pkg::IDX_CID_LO:   company_id_next[7:0]     = data_byte;
      earec_pkg::IDX_CID_HI:   company_id_next[15:8]    = data_byte;
      earec_pkg::IDX_CTR_LO:   counter_value_next[7:0]  = data_byte;
      earec_pkg::IDX_CTR_HI:   counter_value_next[15:8] = data_byte;
      earec_pkg::IDX_KEYCHECK: key_check_byte_next      = data_byte;
      default: begin
        for (int i = 0; i < earec_pkg::CIPHER_USED; i++) begin
          if (byte_count == earec_pkg::CIPHER_START + 5'(i)) cipher_next[i] = data_byte;
        end
      end
    endcase
    count_sat = (byte_count < earec_pkg::COUNT_MAX) ? byte_count + 5'd1 : byte_count;
    byte_count_next = byte_count;
    if (accept) byte_count_next = last_byte ? 5'd0 : count_sat;

    if (count_sat < earec_pkg::SHORT_RECORD)                status = earec_pkg::ST_SHORT;
    else if (company_id_next != earec_pkg::COMPANY_ID_OK)   status = earec_pkg::ST_COMPANY;
    else if (address_filter_on && sender_address != target_address)
                                                            status = earec_pkg::ST_ADDRESS;
    else if (count_sat < earec_pkg::MIN_RECORD)             status = earec_pkg::ST_UNDER_MIN;
    else if (key_check_byte_next != key_byte0)              status = earec_pkg::ST_KEYCHECK;
    else                                                    status = earec_pkg::ST_OK;

    job.status  = status;
    job.counter = counter_value_next;
    job.cipher  = cipher_next;
    job_push    = accept && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= 5'd0;
      company_id     <= 16'd0;
      counter_value  <= 16'd0;
      key_check_byte <= 8'd0;
    end else begin
      byte_count <= byte_count_next;
      if (accept) begin
        company_id     <= company_id_next;
        counter_value  <= counter_value_next;
        key_check_byte <= key_check_byte_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cipher <= cipher_next;
  end

endmodule
`default_nettype wire

// ----- sv/earec_queue.sv -----
// Job queue between the front end and the decrypt engine.
`timescale 1ns / 1ps
`default_nettype none
module earec_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire earec_pkg::job_t push_job,
  input  wire logic            pop,
  output earec_pkg::job_t      head,
  output logic                 empty,
  output logic                 full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  earec_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? PW'(0) : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

// ----- sv/earec_back.sv -----
// Back end: iterative AES-128 keystream engine, XOR and result register.
`timescale 1ns / 1ps
`default_nettype none
module earec_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire earec_pkg::job_t head,
  input  wire logic            q_empty,
  output logic                 pop,
  input  wire logic [63:0]     key_high,
  input  wire logic [63:0]     key_low,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [63:0]          out_data
);

  earec_pkg::block_t key, ctr, st, rk, rk_next, sub, mix, round_out;
  logic [earec_pkg::CIPHER_USED-1:0][7:0] cipher, plain;
  logic [7:0] rcon;
  logic [3:0] rnd;
  logic       busy, ks_ready, slot_free;
  logic [7:0] t0, t1, t2, t3;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key[i]     = key_high[63-8*i -: 8];
      key[8 + i] = key_low[63-8*i -: 8];
    end
    ctr    = '0;
    ctr[0] = head.counter[7:0];
    ctr[1] = head.counter[15:8];

    // next round key from the current one
    t0 = earec_pkg::sbox(rk[13]) ^ rcon;
    t1 = earec_pkg::sbox(rk[14]);
    t2 = earec_pkg::sbox(rk[15]);
    t3 = earec_pkg::sbox(rk[12]);
    rk_next[0] = rk[0] ^ t0;
    rk_next[1] = rk[1] ^ t1;
    rk_next[2] = rk[2] ^ t2;
    rk_next[3] = rk[3] ^ t3;
    for (int i = 4; i < 16; i++) rk_next[i] = rk[i] ^ rk_next[i-4];

    // sub bytes and shift rows together
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        sub[c*4+j] = earec_pkg::sbox(st[((c + j) % 4) * 4 + j]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      mix[c*4]   = sub[c*4]   ^ (sub[c*4] ^ sub[c*4+1] ^ sub[c*4+2] ^ sub[c*4+3])
                   ^ earec_pkg::xt(sub[c*4]   ^ sub[c*4+1]);
      mix[c*4+1] = sub[c*4+1] ^ (sub[c*4] ^ sub[c*4+1] ^ sub[c*4+2] ^ sub[c*4+3])
                   ^ earec_pkg::xt(sub[c*4+1] ^ sub[c*4+2]);
      mix[c*4+2] = sub[c*4+2] ^ (sub[c*4] ^ sub[c*4+1] ^ sub[c*4+2] ^ sub[c*4+3])
                   ^ earec_pkg::xt(sub[c*4+2] ^ sub[c*4+3]);
      mix[c*4+3] = sub[c*4+3] ^ (sub[c*4] ^ sub[c*4+1] ^ sub[c*4+2] ^ sub[c*4+3])
                   ^ earec_pkg::xt(sub[c*4+3] ^ sub[c*4]);
    end
    round_out = ((rnd == earec_pkg::LAST_ROUND) ? sub : mix) ^ rk_next;

    for (int i = 0; i < earec_pkg::CIPHER_USED; i++) plain[i] = cipher[i] ^ st[i];

    slot_free = !out_valid || out_ready;
    pop       = !q_empty && !busy && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ks_ready  <= 1'b0;
      out_valid <= 1'b0;
      rnd       <= 4'd0;
    end else begin
      if (pop) begin
        // pop only happens with the result slot free
        out_valid <= (head.status != earec_pkg::ST_OK);
        if (head.status == earec_pkg::ST_OK) begin
          busy     <= 1'b1;
          ks_ready <= 1'b0;
          rnd      <= 4'd1;
        end
      end else if (busy && !ks_ready) begin
        rnd <= rnd + 4'd1;
        if (rnd == earec_pkg::LAST_ROUND) ks_ready <= 1'b1;
        if (out_valid && out_ready) out_valid <= 1'b0;
      end else if (busy && ks_ready && slot_free) begin
        out_valid <= 1'b1;
        busy      <= 1'b0;
        ks_ready  <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.status != earec_pkg::ST_OK) begin
        out_data <= {61'd0, head.status};
      end else begin
        st     <= ctr ^ key;
        rk     <= key;
        rcon   <= 8'h01;
        cipher <= head.cipher;
      end
    end else if (busy && !ks_ready) begin
      st   <= round_out;
      rk   <= rk_next;
      rcon <= earec_pkg::xt(rcon);
    end else if (busy && ks_ready && slot_free) begin
      out_data <= {5'd0, plain[9], plain[8], plain[5], plain[4], plain[3], plain[2],
                   plain[0], earec_pkg::ST_OK};
    end
  end

endmodule
`default_nettype wire

// ----- sv/encrypted_advert_record_decoder.sv -----
// Top level: encrypted advertisement record decoder.
// Record bytes are taken one per cycle on the slave side while the queue is not full. At the
// last byte the record is checked and a job enters a short queue; a failed record passes its
// status from the queue into the result register, a good record runs an iterative AES-128
// engine (one round a cycle, round keys made on the fly) before its result enters the result
// register. Good records are at least 20 bytes long; the input stalls only when the queue is
// full. Configuration writes take effect at once.
`timescale 1ns / 1ps
`default_nettype none
module encrypted_advert_record_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // data_byte[7:0], sender_address[55:8]
  input  wire logic        s_tlast,  // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,  // status[2:0], device_state[10:3],
                                     // battery_voltage_raw[26:11],
                                     // battery_current_raw[42:27], solar_power[58:43]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0] key_high, key_low;
  logic [47:0] target_address;
  logic        address_filter_on;
  logic        accept, job_push, q_empty, q_full, pop;
  earec_pkg::job_t job, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high          <= 64'd0;
      key_low           <= 64'd0;
      target_address    <= 48'd0;
      address_filter_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        earec_pkg::REG_KEY_HIGH:    key_high          <= cfg_data;
        earec_pkg::REG_KEY_LOW:     key_low           <= cfg_data;
        earec_pkg::REG_TARGET_ADDR: target_address    <= cfg_data[47:0];
        earec_pkg::REG_ADDR_FILTER: address_filter_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  earec_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_byte        (s_tdata[7:0]),
    .last_byte        (s_tlast),
    .sender_address   (s_tdata[55:8]),
    .key_byte0        (key_high[63:56]),
    .target_address   (target_address),
    .address_filter_on(address_filter_on),
    .job              (job),
    .job_push         (job_push)
  );

  earec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .push_job(job),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  earec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .key_high (key_high),
    .key_low  (key_low),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata)
  );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Testbench for the encrypted advertisement record decoder: random records, AES predictor.
`timescale 1ns / 1ps
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = earec_pkg::REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  encrypted_advert_record_decoder i_dut (.*);

  always #4 clk = ~clk;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  charge;
    logic [15:0] volts;
    logic [15:0] amps;
    logic [15:0] solar;
  } reading_t;

  typedef struct packed {
    logic        last;
    logic [47:0] addr;
    logic [7:0]  data;
  } rec_byte_t;

  // predictor state
  logic [63:0] key_hi_q, key_lo_q;
  logic [47:0] target_q;
  logic        filt_q;
  logic [4:0]  nbytes;
  logic [15:0] cid, ctr;
  logic [7:0]  kchk;
  logic [7:0]  cbuf [12];

  rec_byte_t pending_bytes[$];
  reading_t  expected_readings[$];
  int        errors = 0;
  int        cycles = 0;
  bit        drive_on = 0;
  bit        s_taken = 0;

  function automatic logic [7:0] gmul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic earec_pkg::block_t aes_block(earec_pkg::block_t k,
                                                  earec_pkg::block_t pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] rc, f, a0, a1, a2, a3, e;
    earec_pkg::block_t o;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = k[i];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if ((i % 16) == 0) begin
        f = w[0];
        w[0] = earec_pkg::SBOX[w[1]] ^ rc;
        w[1] = earec_pkg::SBOX[w[2]];
        w[2] = earec_pkg::SBOX[w[3]];
        w[3] = earec_pkg::SBOX[f];
        rc = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[i] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[c*4+j] = earec_pkg::SBOX[s[((c+j)%4)*4+j]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          e = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ e ^ gmul2(a0 ^ a1);
          t[c*4+1] = a1 ^ e ^ gmul2(a1 ^ a2);
          t[c*4+2] = a2 ^ e ^ gmul2(a2 ^ a3);
          t[c*4+3] = a3 ^ e ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r*16+i];
    end
    for (int i = 0; i < 16; i++) o[i] = s[i];
    return o;
  endfunction

  task automatic predict_byte(rec_byte_t b);
    earec_pkg::block_t k, cb, ks;
    reading_t r;
    if (nbytes == earec_pkg::IDX_CID_LO) cid[7:0] = b.data;
    else if (nbytes == earec_pkg::IDX_CID_HI) cid[15:8] = b.data;
    else if (nbytes == earec_pkg::IDX_CTR_LO) ctr[7:0] = b.data;
    else if (nbytes == earec_pkg::IDX_CTR_HI) ctr[15:8] = b.data;
    else if (nbytes == earec_pkg::IDX_KEYCHECK) kchk = b.data;
    else if (nbytes >= earec_pkg::CIPHER_START && nbytes < earec_pkg::CIPHER_START + 5'd12)
      cbuf[nbytes - earec_pkg::CIPHER_START] = b.data;
    if (nbytes < earec_pkg::COUNT_MAX) nbytes++;
    if (!b.last) return;
    for (int i = 0; i < 8; i++) begin
      k[i] = key_hi_q[63-8*i -: 8];
      k[8+i] = key_lo_q[63-8*i -: 8];
    end
    r = '0;
    if (nbytes < earec_pkg::SHORT_RECORD) r.status = earec_pkg::ST_SHORT;
    else if (cid != earec_pkg::COMPANY_ID_OK) r.status = earec_pkg::ST_COMPANY;
    else if (filt_q && b.addr != target_q) r.status = earec_pkg::ST_ADDRESS;
    else if (nbytes < earec_pkg::MIN_RECORD) r.status = earec_pkg::ST_UNDER_MIN;
    else if (kchk != k[0]) r.status = earec_pkg::ST_KEYCHECK;
    else r.status = earec_pkg::ST_OK;
    nbytes = '0;
    if (r.status == earec_pkg::ST_OK) begin
      cb = '0; cb[0] = ctr[7:0]; cb[1] = ctr[15:8];
      ks = aes_block(k, cb);
      r.charge = cbuf[0] ^ ks[0];
      r.volts = {cbuf[3] ^ ks[3], cbuf[2] ^ ks[2]};
      r.amps = {cbuf[5] ^ ks[5], cbuf[4] ^ ks[4]};
      r.solar = {cbuf[9] ^ ks[9], cbuf[8] ^ ks[8]};
    end
    expected_readings.push_back(r);
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // request acceptance is judged at the rising edge
  always @(posedge clk) begin
    s_taken = !rst && s_tvalid && s_tready;
    if (s_taken) predict_byte({s_tlast, s_tdata[55:8], s_tdata[7:0]});
  end

  // driver
  int s_gap = 0;
  always @(negedge clk) begin
    if (s_taken) s_gap = gap_len();
    if (!s_tvalid || s_taken) begin
      if (drive_on && pending_bytes.size() > 0 && (s_gap == 0 || $urandom_range(0, 3) == 0)) begin
        rec_byte_t b;
        b = pending_bytes.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {b.addr, b.data};
        s_tlast <= b.last;
      end else begin
        s_tvalid <= 1'b0;
        if (s_gap > 0) s_gap--;
      end
    end
  end

  // sink: random m_tready back-pressure
  int m_gap = 0;
  always @(negedge clk) begin
    if (m_gap > 0) begin m_gap--; m_tready <= 1'b0; end
    else begin m_tready <= 1'b1; m_gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0; end
  end

  always @(posedge clk) begin
    reading_t got, exp_r;
    cycles++;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[2:0], m_tdata[10:3], m_tdata[26:11], m_tdata[42:27], m_tdata[58:43]};
      if (expected_readings.size() == 0) begin
        $error("unexpected result %h", m_tdata); errors++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (got.status != exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++; end
        if (got.charge != exp_r.charge) begin
          $error("device_state exp %0d got %0d", exp_r.charge, got.charge); errors++; end
        if (got.volts != exp_r.volts) begin
          $error("battery_voltage_raw exp %0d got %0d", $signed(exp_r.volts),
                 $signed(got.volts)); errors++; end
        if (got.amps != exp_r.amps) begin
          $error("battery_current_raw exp %0d got %0d", $signed(exp_r.amps),
                 $signed(got.amps)); errors++; end
        if (got.solar != exp_r.solar) begin
          $error("solar_power exp %0d got %0d", exp_r.solar, got.solar); errors++; end
      end
    end
    if (cycles > 400000) begin
      $display("encrypted_advert_record_decoder test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      earec_pkg::REG_KEY_HIGH:    key_hi_q = val;
      earec_pkg::REG_KEY_LOW:     key_lo_q = val;
      earec_pkg::REG_TARGET_ADDR: target_q = val[47:0];
      earec_pkg::REG_ADDR_FILTER: filt_q = val[0];
      default: ;
    endcase
  endtask

  // builds one record; kind 1 breaks the company id, kind 2 the key check byte, others keep both
  task automatic add_record(int len, int kind, logic [47:0] addr);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom());
      if (kind != 1 && i == 0) b = earec_pkg::COMPANY_ID_OK[7:0];
      if (kind != 1 && i == 1) b = earec_pkg::COMPANY_ID_OK[15:8];
      if (kind != 2 && i == 9) b = key_hi_q[63:56];
      pending_bytes.push_back({(i == len - 1), addr, b});
    end
  endtask

  task automatic run_phase(int nrec);
    int len, kind;
    logic [47:0] a;
    for (int n = 0; n < nrec; n++) begin
      kind = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
      len = (kind == 3) ? $urandom_range(1, 31) : $urandom_range(20, 34);
      a = ($urandom_range(0, 2) == 0) ? 48'({$urandom(), $urandom()}) : target_q;
      add_record(len, kind, a);
    end
    drive_on = 1;
    while (pending_bytes.size() > 0 || s_tvalid || expected_readings.size() > 0)
      @(posedge clk);
    drive_on = 0;
    repeat (30) @(posedge clk);
  endtask

  initial begin
    key_hi_q = '0; key_lo_q = '0; target_q = '0; filt_q = 1'b0;
    nbytes = '0; cid = '0; ctr = '0; kchk = '0;
    for (int i = 0; i < 12; i++) cbuf[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: short, exact boundary lengths, wrong company, key check, saturation
    add_record(1, 0, '0);
    add_record(7, 0, '0);
    add_record(8, 0, '0);
    add_record(19, 0, '0);
    add_record(20, 0, '0);
    add_record(20, 1, '0);
    add_record(22, 2, '0);
    add_record(40, 0, 48'hFFFF_FFFF_FFFF);
    drive_on = 1;
    while (pending_bytes.size() > 0 || s_tvalid || expected_readings.size() > 0)
      @(posedge clk);
    drive_on = 0;
    repeat (30) @(posedge clk);
    write_reg(earec_pkg::REG_KEY_HIGH, '1);
    write_reg(earec_pkg::REG_KEY_LOW, '1);
    write_reg(earec_pkg::REG_TARGET_ADDR, 64'hFFFF_FFFF_FFFF);
    write_reg(earec_pkg::REG_ADDR_FILTER, 64'd1);
    run_phase(14);
    for (int p = 0; p < 4; p++) begin
      write_reg(earec_pkg::REG_KEY_HIGH, {$urandom(), $urandom()});
      write_reg(earec_pkg::REG_KEY_LOW, {$urandom(), $urandom()});
      write_reg(earec_pkg::REG_TARGET_ADDR, {$urandom(), $urandom()});
      write_reg(earec_pkg::REG_ADDR_FILTER, 64'(p % 2));
      run_phase(14);
    end
    write_reg(earec_pkg::REG_TARGET_ADDR, '0);
    write_reg(earec_pkg::REG_ADDR_FILTER, '0);
    run_phase(5);
    if (errors == 0)
      $display("encrypted_advert_record_decoder test passed");
    else
      $display("encrypted_advert_record_decoder test failed");
    $finish;
  end
endmodule

// ----- files.f -----
sv/earec_pkg.sv
sv/earec_front.sv
sv/earec_queue.sv
sv/earec_back.sv
sv/encrypted_advert_record_decoder.sv
verif/testbench.sv
